// ----- hw/rtl/nfcfb_pkg.sv -----
package nfcfb_pkg;

  // Command queue between the front and back parts.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  // Fixed frame bytes.
  localparam logic [7:0] PREAMBLE_BYTE  = 8'h00;
  localparam logic [7:0] START_CODE_HI  = 8'hFF;
  localparam logic [7:0] POSTAMBLE_BYTE = 8'h00;

  // Frame identifier after reset (host to controller).
  localparam logic [7:0] IDENT_RESET = 8'hD4;

  // Accepted payload length range.
  localparam logic [7:0] LEN_MIN = 8'd1;
  localparam logic [7:0] LEN_MAX = 8'd254;

  // One classified payload word as handed from the front to the back.
  typedef struct packed {
    logic       first;     // first payload byte, header goes out before it
    logic       last;      // last payload byte, DCS and postamble follow it
    logic [7:0] data;      // payload byte
    logic [7:0] lenfield;  // LEN field (payload length plus one)
    logic [7:0] ident;     // frame identifier latched for this frame
    logic [7:0] dcs;       // data checksum, valid with last
  } cmd_t;

endpackage

// ----- hw/rtl/nfcfb_ifs.sv -----
// Payload input channel.
interface nfcfb_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [7:0] payload_len;

  modport source(output valid, output payload_byte, output payload_len, input ready);
  modport sink(input valid, input payload_byte, input payload_len, output ready);
endinterface

// Framed byte output channel.
interface nfcfb_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_frame;

  modport source(output valid, output out_byte, output end_of_frame, input ready);
  modport sink(input valid, input out_byte, input end_of_frame, output ready);
endinterface

// Configuration write channel for the frame identifier register.
interface nfcfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_identifier;

  modport source(output valid, output frame_identifier, input ready);
  modport sink(input valid, input frame_identifier, output ready);
endinterface

// ----- hw/rtl/nfcfb_front.sv -----
module nfcfb_front (
  input  logic                clk,
  input  logic                rst,
  nfcfb_cfg_if.sink           cfg,
  nfcfb_cmd_if.sink           cmd,
  input  logic                q_full,
  output logic                q_push,
  output nfcfb_pkg::cmd_t     q_word
);

  logic       in_frame;
  logic [7:0] bytes_left;
  logic [7:0] running_sum;
  logic [7:0] ident;

  logic       first;
  logic [7:0] len_clamped;
  logic [7:0] bytes_next;
  logic [7:0] sum_next;
  logic       last;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ident <= nfcfb_pkg::IDENT_RESET;
    end else if (cfg.valid) begin
      ident <= cfg.frame_identifier;
    end
  end

  // Accept a word whenever the queue has room.
  assign cmd.ready = !q_full;
  assign q_push    = cmd.valid && !q_full;

  // Clamp the length into the legal range.
  always_comb begin
    if (cmd.payload_len < nfcfb_pkg::LEN_MIN) begin
      len_clamped = nfcfb_pkg::LEN_MIN;
    end else if (cmd.payload_len > nfcfb_pkg::LEN_MAX) begin
      len_clamped = nfcfb_pkg::LEN_MAX;
    end else begin
      len_clamped = cmd.payload_len;
    end
  end

  // Classify the word and update the checksum and remaining count.
  assign first      = !in_frame;
  assign bytes_next = (first ? len_clamped : bytes_left) - 8'd1;
  assign sum_next   = (first ? ident : running_sum) + cmd.payload_byte;
  assign last       = (bytes_next == 8'd0);

  always_comb begin
    q_word.first    = first;
    q_word.last     = last;
    q_word.data     = cmd.payload_byte;
    q_word.lenfield = len_clamped + 8'd1;
    q_word.ident    = ident;
    q_word.dcs      = 8'd0 - sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      bytes_left  <= 8'd0;
      running_sum <= 8'd0;
    end else if (q_push) begin
      in_frame    <= !last;
      bytes_left  <= bytes_next;
      running_sum <= last ? 8'd0 : sum_next;
    end
  end

endmodule

// ----- hw/rtl/nfcfb_fifo.sv -----
module nfcfb_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  nfcfb_pkg::cmd_t     push_word,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output nfcfb_pkg::cmd_t     head
);

  nfcfb_pkg::cmd_t                 entries [nfcfb_pkg::FIFO_DEPTH];
  logic [nfcfb_pkg::PTR_W-1:0]     wr_ptr;
  logic [nfcfb_pkg::PTR_W-1:0]     rd_ptr;
  logic [nfcfb_pkg::CNT_W-1:0]     count;

  assign full      = (count == nfcfb_pkg::CNT_W'(nfcfb_pkg::FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/nfcfb_back.sv -----
module nfcfb_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_not_empty,
  input  nfcfb_pkg::cmd_t     q_head,
  output logic                q_pop,
  nfcfb_frame_if.source       frame
);

  typedef enum logic [9:0] {
    S_NEXT = 10'b00_0000_0001,
    S_PRE  = 10'b00_0000_0010,
    S_SC0  = 10'b00_0000_0100,
    S_SC1  = 10'b00_0000_1000,
    S_LEN  = 10'b00_0001_0000,
    S_LCS  = 10'b00_0010_0000,
    S_ID   = 10'b00_0100_0000,
    S_DATA = 10'b00_1000_0000,
    S_DCS  = 10'b01_0000_0000,
    S_POST = 10'b10_0000_0000
  } step_t;

  step_t      step;
  step_t      step_next;
  step_t      cur;
  logic       adv;
  logic [7:0] byte_next;
  logic       eof_next;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_eof;

  // A byte is produced when a word is waiting and the output register is free.
  assign adv = q_not_empty && (!out_valid || frame.ready);

  // At the start of a word, pick the header or go straight to the data.
  always_comb begin
    if (step == S_NEXT) begin
      cur = q_head.first ? S_PRE : S_DATA;
    end else begin
      cur = step;
    end
  end

  // Byte selection and the following step.
  always_comb begin
    byte_next = nfcfb_pkg::PREAMBLE_BYTE;
    eof_next  = 1'b0;
    step_next = S_NEXT;
    q_pop     = 1'b0;
    unique case (cur)
      S_PRE: begin
        step_next = S_SC0;
      end
      S_SC0: begin
        step_next = S_SC1;
      end
      S_SC1: begin
        byte_next = nfcfb_pkg::START_CODE_HI;
        step_next = S_LEN;
      end
      S_LEN: begin
        byte_next = q_head.lenfield;
        step_next = S_LCS;
      end
      S_LCS: begin
        byte_next = 8'd0 - q_head.lenfield;
        step_next = S_ID;
      end
      S_ID: begin
        byte_next = q_head.ident;
        step_next = S_DATA;
      end
      S_DATA: begin
        byte_next = q_head.data;
        step_next = q_head.last ? S_DCS : S_NEXT;
        q_pop     = adv && !q_head.last;
      end
      S_DCS: begin
        byte_next = q_head.dcs;
        step_next = S_POST;
      end
      S_POST: begin
        byte_next = nfcfb_pkg::POSTAMBLE_BYTE;
        eof_next  = 1'b1;
        step_next = S_NEXT;
        q_pop     = adv;
      end
      default: begin
        step_next = S_NEXT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_NEXT;
    end else if (adv) begin
      step <= step_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte <= byte_next;
      out_eof  <= eof_next;
    end
  end

  assign frame.valid        = out_valid;
  assign frame.out_byte     = out_byte;
  assign frame.end_of_frame = out_eof;

endmodule

// ----- hw/rtl/nfc_command_frame_builder_core.sv -----
// Builds normal information frames for an NFC controller from a stream of
// payload bytes.
// The cmd channel takes one payload word per handshake; payload_len is
// sampled only on the first word of a frame (0 counts as 1, 255 as 254).
// The frame channel delivers one byte per word: 00 00 FF LEN LCS ID, the
// payload, DCS and a 00 postamble flagged with end_of_frame.
// The cfg channel writes the frame identifier (0xD4 after reset); it is
// always ready and is used at the start of the next frame.
// The first output byte of a word passes through the command queue and then
// the output register. Throughput: one output byte per cycle while the
// receiver is ready; a mid-frame payload word is accepted every cycle while
// the queue has room, and the six header bytes and the two trailer bytes
// are extra output bytes, absorbed by a four-entry queue.
// Reset clears the frame state, the command queue and the output register,
// and restores the identifier.
// When the receiver stalls, the output byte holds, the queue fills and cmd
// ready drops once the queue is full.
module nfc_command_frame_builder_core (
  input  logic            clk,
  input  logic            rst,
  nfcfb_cfg_if.sink       cfg,
  nfcfb_cmd_if.sink       cmd,
  nfcfb_frame_if.source   frame
);

  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_not_empty;
  nfcfb_pkg::cmd_t     q_word;
  nfcfb_pkg::cmd_t     q_head;

  // Front: accepts and classifies payload words.
  nfcfb_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (cmd),
    .q_full (q_full),
    .q_push (q_push),
    .q_word (q_word)
  );

  // Queue between front and back.
  nfcfb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_word),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Back: expands each word into frame bytes.
  nfcfb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .frame       (frame)
  );

endmodule

// ----- tb/nfcfb_frame_checker.sv -----
module nfcfb_frame_checker
  import nfcfb_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  nfcfb_cfg_if   cfg,
  nfcfb_cmd_if   cmd,
  nfcfb_frame_if frame,
  output int     error_count,
  output int     pending_bytes
);
  timeunit 1ns;
  timeprecision 1ps;

  // One byte of the framed command as it should appear on the wire.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } wire_byte_t;

  wire_byte_t expected_bytes[$];

  // Own copy of the frame state and the identifier register.
  logic [7:0] ident_reg;
  logic       frame_open;
  logic [7:0] bytes_left;
  logic [7:0] checksum_acc;
  int         mismatches;

  function automatic void note_error(string msg);
    if (mismatches < 10) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatches++;
  endfunction

  function automatic void expect_byte(logic [7:0] value, logic last);
    wire_byte_t item;
    item.value = value;
    item.last  = last;
    expected_bytes.push_back(item);
  endfunction

  // Works out every byte that one accepted payload word puts on the wire.
  function automatic void frame_payload_word(logic [7:0] data, logic [7:0] len_in);
    logic [7:0] count;
    logic [7:0] len_field;
    if (!frame_open) begin
      // The length is clamped into the legal range, so LEN never wraps.
      count = len_in;
      if (count < LEN_MIN) begin
        count = LEN_MIN;
      end
      if (count > LEN_MAX) begin
        count = LEN_MAX;
      end
      len_field = count + 8'd1;
      // Preamble, then the start code 00 FF.
      expect_byte(PREAMBLE_BYTE, 1'b0);
      expect_byte(8'h00, 1'b0);
      expect_byte(START_CODE_HI, 1'b0);
      expect_byte(len_field, 1'b0);
      expect_byte(8'(8'd0 - len_field), 1'b0);
      expect_byte(ident_reg, 1'b0);
      checksum_acc = ident_reg;
      bytes_left   = count;
      frame_open   = 1'b1;
    end
    expect_byte(data, 1'b0);
    checksum_acc = checksum_acc + data;
    bytes_left   = bytes_left - 8'd1;
    // The last payload byte closes the frame with DCS and the postamble.
    if (bytes_left == 8'd0) begin
      expect_byte(8'(8'd0 - checksum_acc), 1'b0);
      expect_byte(POSTAMBLE_BYTE, 1'b1);
      frame_open   = 1'b0;
      checksum_acc = 8'd0;
    end
  endfunction

  function automatic void check_wire_byte(logic [7:0] got, logic got_last);
    wire_byte_t want;
    if (expected_bytes.size() == 0) begin
      note_error($sformatf("unexpected word out_byte %02h end_of_frame %0b", got, got_last));
    end else begin
      want = expected_bytes.pop_front();
      if (got !== want.value) begin
        note_error($sformatf("out_byte expected %02h actual %02h", want.value, got));
      end
      if (got_last !== want.last) begin
        note_error($sformatf("end_of_frame expected %0b actual %0b (out_byte %02h)",
                             want.last, got_last, got));
      end
    end
  endfunction

  // Everything is sampled at the rising edge, with the values of that edge.
  always @(posedge clk) begin
    if (rst) begin
      ident_reg    = IDENT_RESET;
      frame_open   = 1'b0;
      bytes_left   = 8'd0;
      checksum_acc = 8'd0;
      expected_bytes.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        ident_reg = cfg.frame_identifier;
      end
      if (cmd.valid && cmd.ready) begin
        frame_payload_word(cmd.payload_byte, cmd.payload_len);
      end
      if (frame.valid && frame.ready) begin
        check_wire_byte(frame.out_byte, frame.end_of_frame);
      end
    end
    pending_bytes <= expected_bytes.size();
    error_count   <= mismatches;
  end

endmodule

// ----- tb/nfc_command_frame_builder_core_test.sv -----
module nfc_command_frame_builder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nfcfb_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_WORDS    = 8;

  logic clk;
  logic rst;
  int   error_count;
  int   pending_bytes;
  int   idle_cycles;
  bit   calm;

  nfcfb_cfg_if   cfg_ch ();
  nfcfb_cmd_if   cmd_ch ();
  nfcfb_frame_if frame_ch ();

  nfc_command_frame_builder_core dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .cmd   (cmd_ch),
    .frame (frame_ch)
  );

  nfcfb_frame_checker frame_check (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg_ch),
    .cmd           (cmd_ch),
    .frame         (frame_ch),
    .error_count   (error_count),
    .pending_bytes (pending_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Payload bytes lean toward the extremes.
  function automatic logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) begin
      return 8'h00;
    end
    if (roll == 1) begin
      return 8'hFF;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Output side: random stalls unless the current stretch is calm.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    frame_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        frame_ch.ready = 1'b0;
        stall_left--;
      end else begin
        frame_ch.ready = 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Ends the run when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (frame_ch.valid && frame_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one payload word, waits until it is taken, and now and then adds a random gap before it returns.
  task automatic send_word(input logic [7:0] data, input logic [7:0] len_field);
    cmd_ch.payload_byte = data;
    cmd_ch.payload_len  = len_field;
    cmd_ch.valid        = 1'b1;
    @(posedge clk);
    while (!cmd_ch.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid = 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
  endtask

  // Holds off the sender until every expected byte has come out.
  task automatic drain();
    cmd_ch.valid = 1'b0;
    while (pending_bytes != 0) begin
      @(negedge clk);
    end
  endtask

  // The identifier is only written once the block has gone quiet.
  task automatic write_ident(input logic [7:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.frame_identifier = value;
    cfg_ch.valid            = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // A whole frame; the length field of later words is noise the block ignores.
  task automatic send_frame(input logic [7:0] len_field, input int pause_at);
    int count;
    count = len_field;
    if (len_field < LEN_MIN) begin
      count = LEN_MIN;
    end
    if (len_field > LEN_MAX) begin
      count = LEN_MAX;
    end
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        drain();
      end
      send_word(pick_byte(), (i == 0) ? len_field : 8'($urandom_range(0, 255)));
    end
  endtask

  // Random frames, mostly short, some with a pause part way through.
  task automatic run_random_frames(input int words);
    int         sent;
    int         roll;
    int         pause_at;
    logic [7:0] len_field;
    sent = 0;
    while (sent < words) begin
      roll = $urandom_range(0, 19);
      if (roll < 2) begin
        len_field = 8'($urandom_range(0, 1));
      end else if (roll < 17) begin
        len_field = 8'($urandom_range(2, 6));
      end else begin
        len_field = 8'($urandom_range(7, 24));
      end
      pause_at = -1;
      if ($urandom_range(0, 7) == 0) begin
        pause_at = $urandom_range(0, len_field);
      end
      calm = ($urandom_range(0, 5) == 0);
      send_frame(len_field, pause_at);
      sent += (len_field == 8'd0) ? 1 : int'(len_field);
    end
    calm = 1'b0;
  endtask

  initial begin
    cfg_ch.valid            = 1'b0;
    cfg_ch.frame_identifier = 8'h00;
    cmd_ch.valid            = 1'b0;
    cmd_ch.payload_byte     = 8'h00;
    cmd_ch.payload_len      = 8'h00;
    calm                    = 1'b1;
    rst                     = 1'b1;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed frames with the identifier left at its reset value.
    // A zero length counts as one, so this is a complete one-byte frame.
    send_word(8'h00, 8'h00);
    send_word(8'hFF, LEN_MIN);
    calm = 1'b0;
    // Two bytes whose sum wraps, with a large ignored length on the second.
    send_word(8'hFF, 8'd2);
    send_word(8'hFF, 8'h80);
    // Three bytes; the sender waits for the output to drain mid-frame.
    send_word(8'h80, 8'd3);
    send_word(8'h7F, 8'hFF);
    drain();
    send_word(8'h01, 8'h00);

    // Identifier at the low extreme, then random frames.
    write_ident(8'h00);
    run_random_frames(35);

    // Identifier at the high extreme.
    write_ident(8'hFF);
    run_random_frames(30);

    // A random identifier for the next stretch.
    write_ident(8'($urandom_range(0, 255)));
    run_random_frames(30);

    // The longest length opens a frame that the run leaves unfinished:
    // 255 counts as 254, so the header carries LEN FF and LCS 01.
    for (int i = 0; i < LONG_WORDS; i++) begin
      send_word(pick_byte(), (i == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
    end

    drain();
    repeat (10) @(negedge clk);
    if (error_count == 0 && pending_bytes == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
